// ===== design/template_type_name_demangler_defines.svh =====
// ----------------------------------------------------------------------------
// Template type-name demangler: assertion macros
// Shared concurrent assertion forms used by the demangler modules.
// ----------------------------------------------------------------------------
`ifndef TEMPLATE_TYPE_NAME_DEMANGLER_DEFINES_SVH
`define TEMPLATE_TYPE_NAME_DEMANGLER_DEFINES_SVH

// The expression holds at every clock edge outside reset.
`define TTND_ASSERT_ALWAYS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define TTND_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define TTND_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/ttnd_pkg.sv =====
// ----------------------------------------------------------------------------
// Template type-name demangler package
// Character constants, error codes and the result bundle passed from the
// parser to the output serialiser.
// ----------------------------------------------------------------------------
package ttnd_pkg;

   localparam int LEN_BITS_DEF    = 8;
   localparam int QUEUE_DEPTH_DEF = 4;

   localparam logic [7:0] CH_T     = 8'h74;
   localparam logic [7:0] CH_Z     = 8'h5A;
   localparam logic [7:0] CH_LT    = 8'h3C;
   localparam logic [7:0] CH_GT    = 8'h3E;
   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;

   localparam logic [1:0] ERR_NONE     = 2'd0;
   localparam logic [1:0] ERR_MISS_Z   = 2'd1;
   localparam logic [1:0] ERR_TRUNC    = 2'd2;
   localparam logic [1:0] ERR_OVERFLOW = 2'd3;

   // Up to three results caused by one request.
   typedef struct packed {
      logic [1:0]      count;
      logic [2:0][7:0] chars;
      logic            has_char;
      logic            last;
      logic [1:0]      error;
   } bundle_type;

endpackage

// ===== design/ttnd_front.sv =====
// ----------------------------------------------------------------------------
// Template type-name demangler: parser front end
// Accepts one request per cycle while accept_i is high, advances the parse
// state and hands the results that the byte causes to the queue as one bundle.
// ----------------------------------------------------------------------------
module ttnd_front #(
   parameter int LEN_BITS = ttnd_pkg::LEN_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept_i,
   input  logic [7:0]            char_i,
   input  logic                  last_i,
   output logic                  push_o,
   output ttnd_pkg::bundle_type  bundle_o
);

   typedef enum logic [9:0] {
      PH_START     = 10'b00_0000_0001,
      PH_PLAIN_DIG = 10'b00_0000_0010,
      PH_PASS      = 10'b00_0000_0100,
      PH_BASE_LEN  = 10'b00_0000_1000,
      PH_BASE_COPY = 10'b00_0001_0000,
      PH_COUNT     = 10'b00_0010_0000,
      PH_ZED       = 10'b00_0100_0000,
      PH_PLEN      = 10'b00_1000_0000,
      PH_PCOPY     = 10'b01_0000_0000,
      PH_DISCARD   = 10'b10_0000_0000
   } phase_type;

   localparam int PROD_W = LEN_BITS + 4;

   phase_type           phase_ff, phase_in;
   logic [LEN_BITS-1:0] copy_ff, copy_in;
   logic [LEN_BITS-1:0] params_ff, params_in;
   logic [1:0]          errc_ff, errc_in;

   logic                is_dig;
   logic [LEN_BITS-1:0] acc_sel;
   logic [PROD_W-1:0]   acc_wide;
   logic [PROD_W-1:0]   prod;
   logic                acc_ovf;
   logic [LEN_BITS-1:0] acc_new;
   logic [LEN_BITS-1:0] copy_dec;
   logic [LEN_BITS-1:0] params_dec;
   logic [LEN_BITS-1:0] params_n_dec;

   phase_type           ph_n;
   logic [LEN_BITS-1:0] copy_n;
   logic [LEN_BITS-1:0] params_n;
   logic [1:0]          err_c;
   logic [1:0]          nput;
   logic [2:0][7:0]     chars_v;

   assign is_dig     = (char_i >= ttnd_pkg::CH_ZERO) && (char_i <= ttnd_pkg::CH_NINE);
   assign acc_sel    = (phase_ff == PH_COUNT) ? params_ff : copy_ff;
   assign acc_wide   = PROD_W'(acc_sel);
   assign prod       = (acc_wide << 3) + (acc_wide << 1) + PROD_W'(char_i[3:0]);
   assign acc_ovf    = |prod[PROD_W-1:LEN_BITS];
   assign acc_new    = prod[LEN_BITS-1:0];
   assign copy_dec   = copy_ff - LEN_BITS'(1);
   assign params_dec = params_ff - LEN_BITS'(1);

   // Parse one byte; the flush at the final byte closes any open number.
   always_comb begin
      ph_n         = phase_ff;
      copy_n       = copy_ff;
      params_n     = params_ff;
      err_c        = ttnd_pkg::ERR_NONE;
      nput         = 2'd0;
      chars_v      = '0;
      params_n_dec = '0;

      unique case (phase_ff)
         PH_START: begin
            if (char_i == ttnd_pkg::CH_T) begin
               copy_n = '0;
               ph_n   = PH_BASE_LEN;
            end else if (is_dig) begin
               ph_n = PH_PLAIN_DIG;
            end else begin
               chars_v[0] = char_i;
               nput       = 2'd1;
               ph_n       = PH_PASS;
            end
         end
         PH_PLAIN_DIG: begin
            if (!is_dig) begin
               chars_v[0] = char_i;
               nput       = 2'd1;
               ph_n       = PH_PASS;
            end
         end
         PH_BASE_LEN: begin
            if (is_dig) begin
               if (acc_ovf) err_c = ttnd_pkg::ERR_OVERFLOW;
               else copy_n = acc_new;
            end else if (copy_ff != '0) begin
               chars_v[0] = char_i;
               nput       = 2'd1;
               copy_n     = copy_dec;
               ph_n       = PH_BASE_COPY;
               if (copy_dec == '0) begin
                  chars_v[1] = ttnd_pkg::CH_LT;
                  nput       = 2'd2;
                  params_n   = '0;
                  ph_n       = PH_COUNT;
               end
            end else begin
               chars_v[0] = ttnd_pkg::CH_LT;
               chars_v[1] = ttnd_pkg::CH_GT;
               chars_v[2] = char_i;
               nput       = 2'd3;
               params_n   = '0;
               ph_n       = PH_PASS;
            end
         end
         PH_BASE_COPY: begin
            chars_v[0] = char_i;
            nput       = 2'd1;
            copy_n     = copy_dec;
            if (copy_dec == '0) begin
               chars_v[1] = ttnd_pkg::CH_LT;
               nput       = 2'd2;
               params_n   = '0;
               ph_n       = PH_COUNT;
            end
         end
         PH_COUNT: begin
            if (is_dig) begin
               if (acc_ovf) err_c = ttnd_pkg::ERR_OVERFLOW;
               else params_n = acc_new;
            end else if (params_ff != '0) begin
               if (char_i != ttnd_pkg::CH_Z) begin
                  err_c = ttnd_pkg::ERR_MISS_Z;
               end else begin
                  copy_n = '0;
                  ph_n   = PH_PLEN;
               end
            end else begin
               chars_v[0] = ttnd_pkg::CH_GT;
               chars_v[1] = char_i;
               nput       = 2'd2;
               ph_n       = PH_PASS;
            end
         end
         PH_ZED: begin
            if (char_i != ttnd_pkg::CH_Z) begin
               err_c = ttnd_pkg::ERR_MISS_Z;
            end else begin
               copy_n = '0;
               ph_n   = PH_PLEN;
            end
         end
         PH_PLEN: begin
            if (is_dig) begin
               if (acc_ovf) err_c = ttnd_pkg::ERR_OVERFLOW;
               else copy_n = acc_new;
            end else if (copy_ff != '0) begin
               chars_v[0] = char_i;
               nput       = 2'd1;
               copy_n     = copy_dec;
               ph_n       = PH_PCOPY;
               if (copy_dec == '0) begin
                  params_n = params_dec;
                  if (params_dec == '0) begin
                     chars_v[1] = ttnd_pkg::CH_GT;
                     nput       = 2'd2;
                     ph_n       = PH_PASS;
                  end else begin
                     chars_v[1] = ttnd_pkg::CH_COMMA;
                     chars_v[2] = ttnd_pkg::CH_SPACE;
                     nput       = 2'd3;
                     ph_n       = PH_ZED;
                  end
               end
            end else begin
               params_n = params_dec;
               if (params_dec == '0) begin
                  chars_v[0] = ttnd_pkg::CH_GT;
                  chars_v[1] = char_i;
                  nput       = 2'd2;
                  ph_n       = PH_PASS;
               end else if (char_i != ttnd_pkg::CH_Z) begin
                  err_c = ttnd_pkg::ERR_MISS_Z;
               end else begin
                  chars_v[0] = ttnd_pkg::CH_COMMA;
                  chars_v[1] = ttnd_pkg::CH_SPACE;
                  nput       = 2'd2;
                  copy_n     = '0;
                  ph_n       = PH_PLEN;
               end
            end
         end
         PH_PCOPY: begin
            chars_v[0] = char_i;
            nput       = 2'd1;
            copy_n     = copy_dec;
            if (copy_dec == '0) begin
               params_n = params_dec;
               if (params_dec == '0) begin
                  chars_v[1] = ttnd_pkg::CH_GT;
                  nput       = 2'd2;
                  ph_n       = PH_PASS;
               end else begin
                  chars_v[1] = ttnd_pkg::CH_COMMA;
                  chars_v[2] = ttnd_pkg::CH_SPACE;
                  nput       = 2'd3;
                  ph_n       = PH_ZED;
               end
            end
         end
         default: begin
            chars_v[0] = char_i;
            nput       = 2'd1;
            ph_n       = PH_PASS;
         end
      endcase

      if (last_i && (err_c == ttnd_pkg::ERR_NONE)) begin
         params_n_dec = params_n - LEN_BITS'(1);
         unique case (ph_n) inside
            PH_BASE_LEN: begin
               if (copy_n != '0) begin
                  err_c = ttnd_pkg::ERR_TRUNC;
               end else begin
                  chars_v[0] = ttnd_pkg::CH_LT;
                  chars_v[1] = ttnd_pkg::CH_GT;
                  nput       = 2'd2;
               end
            end
            PH_COUNT: begin
               if (params_n != '0) begin
                  err_c = ttnd_pkg::ERR_TRUNC;
               end else begin
                  chars_v[nput] = ttnd_pkg::CH_GT;
                  nput          = nput + 2'd1;
               end
            end
            PH_PLEN: begin
               if ((copy_n != '0) || (params_n_dec != '0)) begin
                  err_c = ttnd_pkg::ERR_TRUNC;
               end else begin
                  chars_v[nput] = ttnd_pkg::CH_GT;
                  nput          = nput + 2'd1;
               end
            end
            PH_PASS, PH_PLAIN_DIG: begin
            end
            default: begin
               err_c = ttnd_pkg::ERR_TRUNC;
            end
         endcase
      end
   end

   // Build the bundle and the next state.
   always_comb begin
      phase_in          = phase_ff;
      copy_in           = copy_ff;
      params_in         = params_ff;
      errc_in           = errc_ff;
      push_o            = 1'b0;
      bundle_o.count    = 2'd1;
      bundle_o.chars    = '0;
      bundle_o.has_char = 1'b0;
      bundle_o.last     = last_i;
      bundle_o.error    = ttnd_pkg::ERR_NONE;

      if (accept_i) begin
         if (phase_ff == PH_DISCARD) begin
            if (last_i) begin
               push_o         = 1'b1;
               bundle_o.error = errc_ff;
            end
         end else if (err_c != ttnd_pkg::ERR_NONE) begin
            push_o         = 1'b1;
            bundle_o.error = err_c;
            if (!last_i) begin
               phase_in = PH_DISCARD;
               errc_in  = err_c;
            end
         end else begin
            phase_in  = ph_n;
            copy_in   = copy_n;
            params_in = params_n;
            if (nput != 2'd0) begin
               push_o            = 1'b1;
               bundle_o.count    = nput;
               bundle_o.chars    = chars_v;
               bundle_o.has_char = 1'b1;
            end else if (last_i) begin
               push_o = 1'b1;
            end
         end
         if (last_i) begin
            phase_in  = PH_START;
            copy_in   = '0;
            params_in = '0;
            errc_in   = ttnd_pkg::ERR_NONE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_START;
         copy_ff   <= '0;
         params_ff <= '0;
         errc_ff   <= ttnd_pkg::ERR_NONE;
      end else begin
         phase_ff  <= phase_in;
         copy_ff   <= copy_in;
         params_ff <= params_in;
         errc_ff   <= errc_in;
      end
   end

endmodule

// ===== design/ttnd_queue.sv =====
// ----------------------------------------------------------------------------
// Template type-name demangler: bundle queue
// A short first-in first-out queue of result bundles between the parser
// and the output serialiser.
// ----------------------------------------------------------------------------
`include "template_type_name_demangler_defines.svh"

module ttnd_queue #(
   parameter int QUEUE_DEPTH = ttnd_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push_i,
   input  ttnd_pkg::bundle_type  push_data_i,
   input  logic                  pop_i,
   output logic                  full_o,
   output logic                  empty_o,
   output ttnd_pkg::bundle_type  head_o
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   ttnd_pkg::bundle_type entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic                 do_push;
   logic                 do_pop;

   assign full_o  = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign empty_o = (count_ff == '0);
   assign head_o  = entry_ff[rd_ptr_ff];
   assign do_push = push_i && !full_o;
   assign do_pop  = pop_i && !empty_o;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) count_in = count_ff + CNT_W'(1);
      else if (do_pop && !do_push) count_in = count_ff - CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data_i;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   `TTND_ASSERT_IMPLIES(a_no_push_when_full, clock, reset, full_o, !push_i, "push into a full queue")
   `TTND_ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= CNT_W'(QUEUE_DEPTH), "count overrun")
   `TTND_ASSERT_NEXT(a_push_fills, clock, reset, push_i && !full_o && !pop_i, !empty_o, "queue lost a bundle")

endmodule

// ===== design/ttnd_back.sv =====
// ----------------------------------------------------------------------------
// Template type-name demangler: output serialiser
// Takes bundles from the queue and delivers their results one per cycle
// through a registered response stage while rsp_stall is low.
// ----------------------------------------------------------------------------
`include "template_type_name_demangler_defines.svh"

module ttnd_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  empty_i,
   input  ttnd_pkg::bundle_type  head_i,
   output logic                  pop_o,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [7:0]            rsp_char,
   output logic                  rsp_has_char,
   output logic                  rsp_last,
   output logic [1:0]            rsp_error
);

   logic       valid_ff, valid_in;
   logic [1:0] idx_ff, idx_in;
   logic [7:0] char_ff, char_in;
   logic       has_ff, has_in;
   logic       last_ff, last_in;
   logic [1:0] error_ff, error_in;
   logic       load;
   logic       final_item;
   logic [7:0] sel_char;

   assign load       = !empty_i && (!valid_ff || !rsp_stall);
   assign final_item = (idx_ff == (head_i.count - 2'd1));
   assign pop_o      = load && final_item;

   always_comb begin
      case (idx_ff)
         2'd0:    sel_char = head_i.chars[0];
         2'd1:    sel_char = head_i.chars[1];
         default: sel_char = head_i.chars[2];
      endcase
   end

   always_comb begin
      valid_in = valid_ff;
      idx_in   = idx_ff;
      char_in  = char_ff;
      has_in   = has_ff;
      last_in  = last_ff;
      error_in = error_ff;
      if (load) begin
         valid_in = 1'b1;
         idx_in   = final_item ? 2'd0 : idx_ff + 2'd1;
         char_in  = sel_char;
         has_in   = head_i.has_char;
         last_in  = head_i.last && final_item;
         error_in = head_i.error;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 2'd0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      char_ff  <= char_in;
      has_ff   <= has_in;
      last_ff  <= last_in;
      error_ff <= error_in;
   end

   assign rsp_valid    = valid_ff;
   assign rsp_char     = char_ff;
   assign rsp_has_char = has_ff;
   assign rsp_last     = last_ff;
   assign rsp_error    = error_ff;

   `TTND_ASSERT_IMPLIES(a_empty_is_end_or_error, clock, reset, valid_ff && !has_ff, last_ff || (error_ff != ttnd_pkg::ERR_NONE), "empty response that is neither final nor an error")
   `TTND_ASSERT_IMPLIES(a_error_has_no_char, clock, reset, valid_ff && (error_ff != ttnd_pkg::ERR_NONE), !has_ff, "error response carries a byte")

endmodule

// ===== design/template_type_name_demangler.sv =====
// An accepted request passes through the bundle queue to the registered response stage.
// Throughput: one request per cycle while the bundle queue has room; each request
// yields up to three responses, and the serialiser delivers one response per cycle
// while rsp_stall is low.
// Reset is synchronous and active high: parse state returns to start of name,
// the queue empties and no response is valid.
// ----------------------------------------------------------------------------
// Template type-name demangler
// Streams a mangled type name byte by byte and produces the demangled name,
// with a parser front end, a bundle queue and an output serialiser.
// ----------------------------------------------------------------------------
module template_type_name_demangler #(
   parameter int LEN_BITS    = ttnd_pkg::LEN_BITS_DEF,
   parameter int QUEUE_DEPTH = ttnd_pkg::QUEUE_DEPTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_char,
   input  logic       req_last,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_char,
   output logic       rsp_has_char,
   output logic       rsp_last,
   output logic [1:0] rsp_error
);

   logic                 accept;
   logic                 push;
   ttnd_pkg::bundle_type push_data;
   logic                 pop;
   logic                 full;
   logic                 empty;
   ttnd_pkg::bundle_type head;

   assign req_stall = full;
   assign accept    = req_valid && !full;

   ttnd_front #(
      .LEN_BITS(LEN_BITS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .accept_i (accept),
      .char_i   (req_char),
      .last_i   (req_last),
      .push_o   (push),
      .bundle_o (push_data)
   );

   ttnd_queue #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock       (clock),
      .reset       (reset),
      .push_i      (push),
      .push_data_i (push_data),
      .pop_i       (pop),
      .full_o      (full),
      .empty_o     (empty),
      .head_o      (head)
   );

   ttnd_back u_back (
      .clock        (clock),
      .reset        (reset),
      .empty_i      (empty),
      .head_i       (head),
      .pop_o        (pop),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_char     (rsp_char),
      .rsp_has_char (rsp_has_char),
      .rsp_last     (rsp_last),
      .rsp_error    (rsp_error)
   );

endmodule

// ===== test/template_type_name_demangler_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Template type-name demangler testbench
// Streams mangled names through the demangler: template and plain names,
// well-formed and broken ones, with random gaps on the request side and
// random stalls on the response side. A scoreboard parses each accepted
// request itself and checks every response, field by field, in order.
// ----------------------------------------------------------------------------
module template_type_name_demangler_test;

   localparam int LEN_MAX      = (1 << ttnd_pkg::LEN_BITS_DEF) - 1;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int REQUEST_GOAL = 170;

   typedef enum logic [3:0] {
      P_START,
      P_PLAIN_DIGITS,
      P_PASS,
      P_BASE_LEN,
      P_BASE_COPY,
      P_COUNT,
      P_ZED,
      P_PARAM_LEN,
      P_PARAM_COPY,
      P_DISCARD
   } parse_phase_type;

   typedef struct packed {
      logic [7:0] ch;
      logic       has_char;
      logic       last;
      logic [1:0] error;
   } demangled_byte_type;

   class name_demangle_board;
      parse_phase_type    phase;
      int                 copy_left;
      int                 params_left;
      logic [1:0]         held_error;
      logic [7:0]         emitted[$];
      demangled_byte_type awaited[$];
      int                 failures;

      function new();
         restart();
         failures = 0;
      endfunction

      function void restart();
         phase       = P_START;
         copy_left   = 0;
         params_left = 0;
         held_error  = ttnd_pkg::ERR_NONE;
      endfunction

      function bit is_digit(logic [7:0] c);
         return c >= ttnd_pkg::CH_ZERO && c <= ttnd_pkg::CH_NINE;
      endfunction

      function int grown(int acc, logic [7:0] c);
         return acc * 10 + int'(c - ttnd_pkg::CH_ZERO);
      endfunction

      function void end_base_len();
         if (copy_left > 0) begin
            phase = P_BASE_COPY;
         end else begin
            emitted.push_back(ttnd_pkg::CH_LT);
            params_left = 0;
            phase = P_COUNT;
         end
      endfunction

      function void end_count();
         if (params_left > 0) begin
            phase = P_ZED;
         end else begin
            emitted.push_back(ttnd_pkg::CH_GT);
            phase = P_PASS;
         end
      endfunction

      function void param_done();
         params_left = (params_left - 1) & LEN_MAX;
         if (params_left == 0) begin
            emitted.push_back(ttnd_pkg::CH_GT);
            phase = P_PASS;
         end else begin
            emitted.push_back(ttnd_pkg::CH_COMMA);
            emitted.push_back(ttnd_pkg::CH_SPACE);
            phase = P_ZED;
         end
      endfunction

      function void end_param_len();
         if (copy_left > 0) phase = P_PARAM_COPY;
         else param_done();
      endfunction

      // A non-digit that ends a number is parsed again in the phase that follows.
      function logic [1:0] consume(logic [7:0] c);
         logic [1:0] err;
         bit         again;
         int         v;
         err   = ttnd_pkg::ERR_NONE;
         again = 1'b1;
         while (again) begin
            again = 1'b0;
            case (phase)
               P_START: begin
                  if (c == ttnd_pkg::CH_T) begin
                     copy_left = 0;
                     phase = P_BASE_LEN;
                  end else if (is_digit(c)) begin
                     phase = P_PLAIN_DIGITS;
                  end else begin
                     emitted.push_back(c);
                     phase = P_PASS;
                  end
               end
               P_PLAIN_DIGITS: begin
                  if (!is_digit(c)) begin
                     emitted.push_back(c);
                     phase = P_PASS;
                  end
               end
               P_BASE_LEN: begin
                  if (is_digit(c)) begin
                     v = grown(copy_left, c);
                     if (v > LEN_MAX) err = ttnd_pkg::ERR_OVERFLOW;
                     else copy_left = v;
                  end else begin
                     end_base_len();
                     again = 1'b1;
                  end
               end
               P_BASE_COPY: begin
                  emitted.push_back(c);
                  copy_left = (copy_left - 1) & LEN_MAX;
                  if (copy_left == 0) end_base_len();
               end
               P_COUNT: begin
                  if (is_digit(c)) begin
                     v = grown(params_left, c);
                     if (v > LEN_MAX) err = ttnd_pkg::ERR_OVERFLOW;
                     else params_left = v;
                  end else begin
                     end_count();
                     again = 1'b1;
                  end
               end
               P_ZED: begin
                  if (c != ttnd_pkg::CH_Z) begin
                     err = ttnd_pkg::ERR_MISS_Z;
                  end else begin
                     copy_left = 0;
                     phase = P_PARAM_LEN;
                  end
               end
               P_PARAM_LEN: begin
                  if (is_digit(c)) begin
                     v = grown(copy_left, c);
                     if (v > LEN_MAX) err = ttnd_pkg::ERR_OVERFLOW;
                     else copy_left = v;
                  end else begin
                     end_param_len();
                     again = 1'b1;
                  end
               end
               P_PARAM_COPY: begin
                  emitted.push_back(c);
                  copy_left = (copy_left - 1) & LEN_MAX;
                  if (copy_left == 0) param_done();
               end
               default: begin
                  emitted.push_back(c);
                  phase = P_PASS;
               end
            endcase
         end
         return err;
      endfunction

      function logic [1:0] close_name();
         bit again;
         again = 1'b1;
         while (again) begin
            case (phase)
               P_BASE_LEN:  end_base_len();
               P_COUNT:     end_count();
               P_PARAM_LEN: end_param_len();
               default:     again = 1'b0;
            endcase
         end
         return (phase == P_PASS || phase == P_PLAIN_DIGITS) ?
                ttnd_pkg::ERR_NONE : ttnd_pkg::ERR_TRUNC;
      endfunction

      function void await_byte(logic [7:0] ch, logic has_char, logic last, logic [1:0] error);
         demangled_byte_type b;
         b.ch       = ch;
         b.has_char = has_char;
         b.last     = last;
         b.error    = error;
         awaited.push_back(b);
      endfunction

      // Returns 1 when the request is swallowed while discarding after an error.
      function bit note_request(logic [7:0] c, logic last);
         logic [1:0] err;
         int         n;
         if (phase == P_DISCARD) begin
            if (!last) return 1'b1;
            await_byte(8'h00, 1'b0, 1'b1, held_error);
            restart();
            return 1'b0;
         end
         emitted.delete();
         err = consume(c);
         if (err == ttnd_pkg::ERR_NONE && last) err = close_name();
         if (err != ttnd_pkg::ERR_NONE) begin
            await_byte(8'h00, 1'b0, last, err);
            if (last) begin
               restart();
            end else begin
               held_error = err;
               phase = P_DISCARD;
            end
            return 1'b0;
         end
         n = (emitted.size() > 3) ? 3 : emitted.size();
         for (int k = 0; k < n; k++)
            await_byte(emitted[k], 1'b1, last && k == n - 1, ttnd_pkg::ERR_NONE);
         if (last) begin
            if (n == 0) await_byte(8'h00, 1'b0, 1'b1, ttnd_pkg::ERR_NONE);
            restart();
         end
         return 1'b0;
      endfunction

      task report(string what);
         failures++;
         if (failures <= 40) $display("response mismatch: %s", what);
      endtask

      task check_response(logic [7:0] ch, logic has_char, logic last, logic [1:0] error);
         demangled_byte_type want;
         if (awaited.size() == 0) begin
            report($sformatf("unexpected response with char %h", ch));
            return;
         end
         want = awaited.pop_front();
         if (ch !== want.ch) report($sformatf("char %h, expected %h", ch, want.ch));
         if (has_char !== want.has_char)
            report($sformatf("has_char %b, expected %b", has_char, want.has_char));
         if (last !== want.last) report($sformatf("last %b, expected %b", last, want.last));
         if (error !== want.error) report($sformatf("error %0d, expected %0d", error, want.error));
      endtask

      function int pending();
         return awaited.size();
      endfunction
   endclass

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_char = 8'h00;
   logic       req_last = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_char;
   logic       rsp_has_char;
   logic       rsp_last;
   logic [1:0] rsp_error;

   name_demangle_board board;
   logic [7:0]         name_q[$];
   bit                 calm = 1'b0;
   int                 hold_left = 0;
   int                 counted = 0;
   int                 names_sent = 0;
   int                 cycles = 0;

   template_type_name_demangler i_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_char     (req_char),
      .req_last     (req_last),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_char     (rsp_char),
      .rsp_has_char (rsp_has_char),
      .rsp_last     (rsp_last),
      .rsp_error    (rsp_error)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
         board.check_response(rsp_char, rsp_has_char, rsp_last, rsp_error);
         hold_left = calm ? 0 : $urandom_range(0, 5);
      end
   end

   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left = hold_left - 1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   function automatic logic [7:0] any_nondigit();
      logic [7:0] c;
      do c = 8'($urandom_range(0, 255));
      while (c >= ttnd_pkg::CH_ZERO && c <= ttnd_pkg::CH_NINE);
      return c;
   endfunction

   function automatic void add_text(string s);
      foreach (s[i]) name_q.push_back(s[i]);
   endfunction

   function automatic void set_name(string s);
      name_q.delete();
      add_text(s);
   endfunction

   function automatic void add_number(int value);
      if ($urandom_range(0, 7) == 0) name_q.push_back(ttnd_pkg::CH_ZERO);
      add_text($sformatf("%0d", value));
   endfunction

   function automatic void add_field(int len);
      for (int i = 0; i < len; i++)
         name_q.push_back(i == 0 ? any_nondigit() : 8'($urandom_range(0, 255)));
   endfunction

   function automatic void make_name();
      int kind;
      int n;
      int nparams;
      int cut;
      name_q.delete();
      kind = $urandom_range(0, 99);
      if (kind < 55) begin
         name_q.push_back(ttnd_pkg::CH_T);
         n = $urandom_range(0, 4);
         add_number(n);
         add_field(n);
         nparams = $urandom_range(0, 3);
         add_number(nparams);
         repeat (nparams) begin
            name_q.push_back(ttnd_pkg::CH_Z);
            n = $urandom_range(0, 4);
            add_number(n);
            add_field(n);
         end
         repeat ($urandom_range(0, 3)) name_q.push_back(8'($urandom_range(0, 255)));
         if ($urandom_range(0, 4) == 0 && name_q.size() > 1) begin
            if ($urandom_range(0, 1) == 0) begin
               cut = $urandom_range(1, name_q.size() - 1);
               while (name_q.size() > cut) void'(name_q.pop_back());
            end else begin
               name_q[$urandom_range(1, name_q.size() - 1)] = 8'($urandom_range(0, 255));
            end
         end
      end else if (kind < 70) begin
         repeat ($urandom_range(0, 3))
            name_q.push_back(8'(ttnd_pkg::CH_ZERO + $urandom_range(0, 9)));
         repeat ($urandom_range(0, 4)) name_q.push_back(8'($urandom_range(0, 255)));
      end else if (kind < 80) begin
         name_q.push_back(ttnd_pkg::CH_T);
         add_number($urandom_range(200, 999));
         repeat ($urandom_range(0, 3)) name_q.push_back(any_nondigit());
      end else begin
         repeat ($urandom_range(1, 8)) begin
            case ($urandom_range(0, 4))
               0:       name_q.push_back(ttnd_pkg::CH_T);
               1:       name_q.push_back(ttnd_pkg::CH_Z);
               2:       name_q.push_back(8'(ttnd_pkg::CH_ZERO + $urandom_range(0, 9)));
               default: name_q.push_back(8'($urandom_range(0, 255)));
            endcase
         end
      end
      if (name_q.size() == 0) name_q.push_back(8'($urandom_range(0, 255)));
   endfunction

   task automatic send_byte(logic [7:0] c, logic last);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 5);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_char  <= c;
      req_last  <= last;
      do @(posedge clock); while (req_stall !== 1'b0);
      if (!board.note_request(c, last)) counted++;
   endtask

   task automatic send_name();
      foreach (name_q[i]) send_byte(name_q[i], i == name_q.size() - 1);
      names_sent++;
   endtask

   task automatic drain_requests();
      @(negedge clock);
      req_valid <= 1'b0;
      while (board.pending() != 0) @(negedge clock);
   endtask

   initial begin
      board = new();
      repeat (6) @(negedge clock);
      reset <= 1'b0;

      // Extreme bytes, a zero-length parameter closing on the last byte.
      set_name("t1");
      name_q.push_back(8'hFF);
      add_text("1Z0");
      send_name();
      name_q.delete();
      name_q.push_back(8'h00);
      send_name();
      // A lone digit produces nothing but the closing response.
      set_name("7");
      send_name();
      set_name("t");
      send_name();
      // Missing Z, then the remaining bytes are discarded.
      set_name("t1A1Xq");
      send_name();
      set_name("t256x");
      send_name();
      set_name("t2A");
      send_name();
      set_name("42B");
      send_name();
      drain_requests();

      while (counted < REQUEST_GOAL) begin
         calm = ($urandom_range(0, 5) == 0);
         make_name();
         send_name();
         if (names_sent == 30) drain_requests();
      end
      calm = 1'b0;
      drain_requests();
      repeat (20) @(negedge clock);

      if (board.failures == 0 && board.pending() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
